// ===== rtl/core/hbro_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the h-bridge brake/reverse oscillator
// no dependencies; used by the channel interfaces and the top level

package hbro_pkg;

	typedef enum logic [1:0] {
		DIR_STOP  = 2'd0,
		DIR_FWD   = 2'd1,
		DIR_REV   = 2'd2,
		DIR_BRAKE = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		FUNC_SET  = 2'd0,
		FUNC_AUTO = 2'd1,
		FUNC_TIME = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		DRV_LOW  = 2'd0,
		DRV_HIGH = 2'd1,
		DRV_PWM  = 2'd2
	} drv_t;

	// register index, taken from paddr[2]
	localparam logic REG_BRAKE_LEN  = 1'b0;
	localparam logic REG_PWM_PERIOD = 1'b1;

	localparam int unsigned DUTY_W  = 10;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	// period (16b) * duty (10b) + rounding
	localparam int unsigned PROD_W  = 26;
	// x/1000 == (x>>3)/125, and (n*RECIP_125)>>RECIP_SHIFT == n/125 for n < 2**23
	localparam int unsigned DIV_IN_W   = PROD_W - 3;
	localparam int unsigned RECIP_W    = 24;
	localparam int unsigned MULQ_W     = DIV_IN_W + RECIP_W;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;

	localparam logic [DUTY_W-1:0] FULL_DUTY  = 10'd1000;
	localparam logic [PROD_W-1:0] HALF_ROUND = 26'd500;
	localparam logic [TICK_W-1:0] PERIOD_RESET = 16'd1000;
	localparam logic [TICK_W-1:0] CMP_RESET    = 16'd500;
	localparam logic [TICK_W-1:0] PERIOD_MIN   = 16'd2;

	typedef struct packed {
		dir_t              dir;
		logic [DUTY_W-1:0] duty;
		drv_t              fwd;
		drv_t              rev;
		logic              auto_mode;
		logic              auto_on;
		logic              braking;
		logic              cmp_upd;
	} ctl_t;

endpackage

// ===== rtl/core/hbro_if.sv =====
`timescale 1ns / 1ps
// valid/ready channels of the h-bridge controller: command in, bridge state out
// depends on hbro_pkg for field widths

interface hbro_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic [1:0]                    direction;
	logic [hbro_pkg::DUTY_W-1:0]   duty;
	logic [hbro_pkg::TIME_W-1:0]   switch_period;
	logic [hbro_pkg::TIME_W-1:0]   now_ms;

	modport source (
		output valid, func, direction, duty, switch_period, now_ms,
		input  ready
	);
	modport sink (
		input  valid, func, direction, duty, switch_period, now_ms,
		output ready
	);
endinterface

interface hbro_res_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cur_direction;
	logic [hbro_pkg::DUTY_W-1:0]   cur_duty;
	logic [1:0]                    fwd_drive;
	logic [1:0]                    rev_drive;
	logic [hbro_pkg::TICK_W-1:0]   compare_value;
	logic                          auto_mode;
	logic                          auto_on;
	logic                          braking_pending;

	modport source (
		output valid, cur_direction, cur_duty, fwd_drive, rev_drive, compare_value,
		       auto_mode, auto_on, braking_pending,
		input  ready
	);
	modport sink (
		input  valid, cur_direction, cur_duty, fwd_drive, rev_drive, compare_value,
		       auto_mode, auto_on, braking_pending,
		output ready
	);
endinterface

// ===== rtl/core/hbridge_brake_reverse_oscillator.sv =====
`timescale 1ns / 1ps
// h-bridge direction controller with brake-before-reverse and auto oscillation
// depends on hbro_pkg and the channels in hbro_if

// Accepts one command item per clock and returns one bridge-state item per
// command, in order. Sustained rate is one item per cycle while the result
// side is not stalled: the direction/brake state is updated in a single stage
// right after the input register, and the PWM compare value follows in two
// more stages (period*duty, then a reciprocal multiply for the divide by 1000),
// with the 1..period-1 limit in front of the output register. The input side
// stalls only while the output register holds an item that has not been taken
// and every stage behind it is full. Registers brake length (address 0) and
// PWM period (address 4) are to be written by the user over the APB port only
// while no item is in flight; the block does not enforce this. A changed period
// also acts on compare values of items already in the compare stages.

module hbridge_brake_reverse_oscillator (
	input  logic                               clk,
	input  logic                               arst_n,
	hbro_cmd_if.sink                           cmd,
	hbro_res_if.source                         res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hbro_pkg::APB_AW-1:0]        paddr,
	input  logic [hbro_pkg::APB_DW-1:0]        pwdata,
	output logic [hbro_pkg::APB_DW-1:0]        prdata,
	output logic                               pready
);

	localparam int unsigned DW = hbro_pkg::DUTY_W;
	localparam int unsigned TW = hbro_pkg::TIME_W;
	localparam int unsigned KW = hbro_pkg::TICK_W;

	function automatic logic is_driving(hbro_pkg::dir_t d);
		return (d == hbro_pkg::DIR_FWD) || (d == hbro_pkg::DIR_REV);
	endfunction

	function automatic hbro_pkg::dir_t flip_dir(hbro_pkg::dir_t d);
		return (d == hbro_pkg::DIR_FWD) ? hbro_pkg::DIR_REV : hbro_pkg::DIR_FWD;
	endfunction

	function automatic logic [DW-1:0] clamp_duty(logic [DW-1:0] d);
		return (d > hbro_pkg::FULL_DUTY) ? hbro_pkg::FULL_DUTY : d;
	endfunction

	function automatic hbro_pkg::drv_t level(logic active, logic [DW-1:0] d);
		hbro_pkg::drv_t lv;
		if (!active || d == '0) begin
			lv = hbro_pkg::DRV_LOW;
		end else if (d >= hbro_pkg::FULL_DUTY) begin
			lv = hbro_pkg::DRV_HIGH;
		end else begin
			lv = hbro_pkg::DRV_PWM;
		end
		return lv;
	endfunction

	// ---------------- configuration ----------------
	logic [KW-1:0] brake_len_q;
	logic [KW-1:0] pwm_period_q;
	logic [KW-1:0] period_eff;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brake_len_q  <= '0;
			pwm_period_q <= hbro_pkg::PERIOD_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				hbro_pkg::REG_BRAKE_LEN:  brake_len_q  <= pwdata[KW-1:0];
				hbro_pkg::REG_PWM_PERIOD: pwm_period_q <= pwdata[KW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			hbro_pkg::REG_BRAKE_LEN:  prdata = {{(hbro_pkg::APB_DW-KW){1'b0}}, brake_len_q};
			hbro_pkg::REG_PWM_PERIOD: prdata = {{(hbro_pkg::APB_DW-KW){1'b0}}, pwm_period_q};
			default:                  prdata = '0;
		endcase
	end

	assign period_eff = (pwm_period_q < hbro_pkg::PERIOD_MIN) ? hbro_pkg::PERIOD_MIN
		: pwm_period_q;

	// ---------------- pipeline handshake ----------------
	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, adv_out;

	assign adv_out   = !out_valid_q || res.ready;
	assign rdy4      = !v_s4 || adv_out;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign cmd.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v_s1        <= cmd.valid;
			if (rdy2)    v_s2        <= v_s1;
			if (rdy3)    v_s3        <= v_s2;
			if (rdy4)    v_s4        <= v_s3;
			if (adv_out) out_valid_q <= v_s4;
		end
	end

	// ---------------- stage 1: input register ----------------
	hbro_pkg::func_t func_s1;
	hbro_pkg::dir_t  dir_s1;
	logic [DW-1:0]   duty_s1;
	logic [TW-1:0]   sp_s1;
	logic [TW-1:0]   now_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && cmd.valid) begin
			func_s1 <= hbro_pkg::func_t'(cmd.func);
			dir_s1  <= hbro_pkg::dir_t'(cmd.direction);
			duty_s1 <= cmd.duty;
			sp_s1   <= cmd.switch_period;
			now_s1  <= cmd.now_ms;
		end
	end

	// ---------------- control state ----------------
	hbro_pkg::dir_t dir_q, next_dir_q;
	logic [DW-1:0]  duty_q, next_duty_q;
	logic           mode_q, auto_en_q, brake_flag_q;
	logic [TW-1:0]  period_q, last_switch_q, brake_end_q;

	hbro_pkg::dir_t n_dir, n_next_dir;
	logic [DW-1:0]  n_duty, n_next_duty;
	logic           n_mode, n_auto_en, n_brake_flag;
	logic [TW-1:0]  n_period, n_last_switch, n_brake_end;

	logic           sc_en, ap_en;
	hbro_pkg::dir_t sc_target, ap_dir;
	logic [DW-1:0]  sc_duty, ap_duty, duty_c;
	logic           auto_ok;
	logic [TW-1:0]  brake_diff;
	logic           cmp_upd;
	logic [DW-1:0]  cmp_duty;
	hbro_pkg::ctl_t ctl_c;

	always_comb begin
		n_dir         = dir_q;
		n_duty        = duty_q;
		n_mode        = mode_q;
		n_auto_en     = auto_en_q;
		n_period      = period_q;
		n_last_switch = last_switch_q;
		n_brake_flag  = brake_flag_q;
		n_brake_end   = brake_end_q;
		n_next_dir    = next_dir_q;
		n_next_duty   = next_duty_q;
		sc_en         = 1'b0;
		sc_target     = hbro_pkg::DIR_STOP;
		sc_duty       = '0;
		ap_en         = 1'b0;
		ap_dir        = hbro_pkg::DIR_STOP;
		ap_duty       = '0;
		cmp_upd       = 1'b0;
		cmp_duty      = '0;
		duty_c        = clamp_duty(duty_s1);
		auto_ok       = (duty_c != '0) && (sp_s1 != '0);
		brake_diff    = now_s1 - brake_end_q;

		case (func_s1)
			hbro_pkg::FUNC_SET: begin
				n_mode    = 1'b0;
				n_auto_en = 1'b0;
				n_period  = '0;
				sc_en     = 1'b1;
				sc_target = dir_s1;
				sc_duty   = is_driving(dir_s1) ? duty_c : '0;
			end
			hbro_pkg::FUNC_AUTO: begin
				n_mode    = 1'b1;
				n_period  = sp_s1;
				n_auto_en = auto_ok;
				if (!auto_ok) begin
					sc_en     = 1'b1;
					sc_target = hbro_pkg::DIR_STOP;
				end else if (brake_flag_q) begin
					n_next_duty = duty_c;
				end else if (!is_driving(dir_q)) begin
					sc_en     = 1'b1;
					sc_target = hbro_pkg::DIR_FWD;
					sc_duty   = duty_c;
				end else if ((now_s1 - last_switch_q) >= sp_s1) begin
					sc_en     = 1'b1;
					sc_target = flip_dir(dir_q);
					sc_duty   = duty_c;
				end else begin
					ap_en   = 1'b1;
					ap_dir  = dir_q;
					ap_duty = duty_c;
				end
			end
			hbro_pkg::FUNC_TIME: begin
				if (brake_flag_q && !brake_diff[TW-1]) begin
					// brake interval over: apply the pending direction
					n_brake_flag = 1'b0;
					n_brake_end  = '0;
					if (is_driving(next_dir_q)) n_last_switch = now_s1;
					ap_en   = 1'b1;
					ap_dir  = next_dir_q;
					ap_duty = next_duty_q;
				end else if (mode_q && auto_en_q && is_driving(dir_q) && period_q != '0
						&& (now_s1 - last_switch_q) >= period_q) begin
					sc_en     = 1'b1;
					sc_target = flip_dir(dir_q);
					sc_duty   = duty_q;
				end
			end
			default: ;
		endcase

		// direction change, with a brake interval when a driven bridge is reversed or stopped and the brake length is nonzero
		if (sc_en) begin
			if (sc_target == hbro_pkg::DIR_BRAKE) begin
				n_brake_flag = 1'b0;
				n_brake_end  = '0;
				n_next_dir   = hbro_pkg::DIR_BRAKE;
				n_next_duty  = '0;
				ap_en        = 1'b1;
				ap_dir       = hbro_pkg::DIR_BRAKE;
				ap_duty      = '0;
			end else if (brake_len_q != '0 && is_driving(dir_q) && sc_target != dir_q) begin
				n_next_dir   = sc_target;
				n_next_duty  = sc_duty;
				n_brake_flag = 1'b1;
				n_brake_end  = now_s1 + {{(TW-KW){1'b0}}, brake_len_q};
				ap_en        = 1'b1;
				ap_dir       = hbro_pkg::DIR_BRAKE;
				ap_duty      = '0;
			end else begin
				n_brake_flag = 1'b0;
				n_brake_end  = '0;
				n_next_dir   = sc_target;
				n_next_duty  = sc_duty;
				if (is_driving(sc_target)) n_last_switch = now_s1;
				ap_en   = 1'b1;
				ap_dir  = sc_target;
				ap_duty = sc_duty;
			end
		end

		if (ap_en) begin
			if (clamp_duty(ap_duty) != '0 && clamp_duty(ap_duty) < hbro_pkg::FULL_DUTY) begin
				cmp_upd  = 1'b1;
				cmp_duty = clamp_duty(ap_duty);
			end
			n_dir  = ap_dir;
			n_duty = is_driving(ap_dir) ? clamp_duty(ap_duty) : '0;
		end

		ctl_c.dir       = n_dir;
		ctl_c.duty      = n_duty;
		if (n_dir == hbro_pkg::DIR_BRAKE) begin
			ctl_c.fwd = hbro_pkg::DRV_HIGH;
			ctl_c.rev = hbro_pkg::DRV_HIGH;
		end else begin
			ctl_c.fwd = level(n_dir == hbro_pkg::DIR_FWD, n_duty);
			ctl_c.rev = level(n_dir == hbro_pkg::DIR_REV, n_duty);
		end
		ctl_c.auto_mode = n_mode;
		ctl_c.auto_on   = n_auto_en;
		ctl_c.braking   = n_brake_flag;
		ctl_c.cmp_upd   = cmp_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q         <= hbro_pkg::DIR_STOP;
			duty_q        <= '0;
			mode_q        <= 1'b0;
			auto_en_q     <= 1'b0;
			period_q      <= '0;
			last_switch_q <= '0;
			brake_flag_q  <= 1'b0;
			brake_end_q   <= '0;
			next_dir_q    <= hbro_pkg::DIR_STOP;
			next_duty_q   <= '0;
		end else if (v_s1 && rdy2) begin
			dir_q         <= n_dir;
			duty_q        <= n_duty;
			mode_q        <= n_mode;
			auto_en_q     <= n_auto_en;
			period_q      <= n_period;
			last_switch_q <= n_last_switch;
			brake_flag_q  <= n_brake_flag;
			brake_end_q   <= n_brake_end;
			next_dir_q    <= n_next_dir;
			next_duty_q   <= n_next_duty;
		end
	end

	// ---------------- stages 2..4: compare value ----------------
	hbro_pkg::ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic [DW-1:0]                    cmp_duty_s2;
	logic [hbro_pkg::PROD_W-1:0]      prod_s3;
	logic [KW-1:0]                    quo_s4;
	logic [hbro_pkg::PROD_W-1:0]      prod_c;
	logic [hbro_pkg::MULQ_W-1:0]      mulq_c;
	logic [KW-1:0]                    cmp_c;
	logic [KW-1:0]                    cmp_q;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ctl_s2      <= ctl_c;
			cmp_duty_s2 <= cmp_duty;
		end
		if (rdy3 && v_s2) begin
			ctl_s3  <= ctl_s2;
			prod_s3 <= prod_c;
		end
		if (rdy4 && v_s3) begin
			ctl_s4 <= ctl_s3;
			quo_s4 <= mulq_c[hbro_pkg::RECIP_SHIFT +: KW];
		end
	end

	// rounded period*duty, then divide by 1000 through a reciprocal multiply
	assign prod_c = hbro_pkg::PROD_W'(period_eff) * hbro_pkg::PROD_W'(cmp_duty_s2)
		+ hbro_pkg::HALF_ROUND;
	assign mulq_c = hbro_pkg::MULQ_W'(prod_s3[hbro_pkg::PROD_W-1:3])
		* hbro_pkg::MULQ_W'(hbro_pkg::RECIP_125);

	always_comb begin
		if (quo_s4 == '0) begin
			cmp_c = KW'(1);
		end else if (quo_s4 >= period_eff) begin
			cmp_c = period_eff - KW'(1);
		end else begin
			cmp_c = quo_s4;
		end
	end

	// ---------------- output register ----------------
	hbro_pkg::ctl_t ctl_q;
	logic [KW-1:0]  compare_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q <= hbro_pkg::CMP_RESET;
		end else if (adv_out && v_s4 && ctl_s4.cmp_upd) begin
			cmp_q <= cmp_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s4) begin
			ctl_q     <= ctl_s4;
			compare_q <= ctl_s4.cmp_upd ? cmp_c : cmp_q;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.cur_direction   = ctl_q.dir;
	assign res.cur_duty        = ctl_q.duty;
	assign res.fwd_drive       = ctl_q.fwd;
	assign res.rev_drive       = ctl_q.rev;
	assign res.compare_value   = compare_q;
	assign res.auto_mode       = ctl_q.auto_mode;
	assign res.auto_on         = ctl_q.auto_on;
	assign res.braking_pending = ctl_q.braking;

	// ---------------- assertions ----------------
	a_brake_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.braking_pending |-> res.cur_direction == hbro_pkg::DIR_BRAKE)
		else $error("pending brake without brake direction");

	a_duty_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.cur_duty != '0 |->
			(res.cur_direction == hbro_pkg::DIR_FWD || res.cur_direction == hbro_pkg::DIR_REV)
			&& res.cur_duty <= hbro_pkg::FULL_DUTY)
		else $error("nonzero duty while not driving or above full duty");

	a_cmp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.compare_value != '0)
		else $error("compare value of zero");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> res.valid && !res.ready)
		else $error("input stalled while output side is free");

endmodule
